// ===== hdl/sha_pkg.sv =====
// Package for the SHA-256 stream hasher: round constants, initial hash
// values, a rotate helper and the input and result word types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_position;
    logic        final_word;
  } out_word_t;

  typedef logic [31:0] word_t;

  function automatic word_t round_k(input logic [5:0] t);
    word_t k [0:63];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[t];
  endfunction

  function automatic word_t init_h(input logic [2:0] i);
    word_t h [0:7];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[i];
  endfunction

  function automatic word_t ror(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// ===== hdl/sha_if.sv =====
// Valid/ready stream interface with a typed payload.
// Depends on nothing; payload type is a parameter.
`timescale 1ns / 1ps
`default_nettype none
interface sha_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/sha256_stream_hasher_unit.sv =====
// Top level of the SHA-256 stream hasher.
// Depends on sha_pkg, sha_if, sha_queue and sha_engine.
`timescale 1ns / 1ps
`default_nettype none
// Streaming SHA-256. One message byte is taken per input word, packed
// big-endian into 64-byte blocks. A word with end_of_message pads the
// message and, after one or two more compressions, the eight digest words
// leave in order (word_position 0 first, final_word on the last); the
// hasher then starts a fresh message. Bytes enter a four-word queue at one
// per cycle; the back end drains one byte per cycle and stops draining
// while it compresses each full block (64 rounds of one shared round unit
// plus the chaining add), so intake stalls once the queue is full.
// Finishing a message writes the pad bytes one at a time and then both
// length words, runs one or two compressions, two when the marker lands
// past byte 55, then sends the eight output words. On long messages the
// round unit, not the intake, sets the rate.
module sha256_stream_hasher_unit #(
  parameter int unsigned QueueDepth = sha_pkg::QueueDepth
) (
  input  wire logic clk,
  input  wire logic rst,
  sha_if.sink       in_ch,
  sha_if.source     out_ch
);
  import sha_pkg::*;

  logic     q_full, q_empty, q_pop;
  in_word_t q_word;

  // front end: accept while the queue has room
  assign in_ch.ready = !q_full;

  sha_queue #(.Depth(QueueDepth)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_ch.valid),
    .push_word (in_ch.payload),
    .full      (q_full),
    .pop       (q_pop),
    .pop_word  (q_word),
    .empty     (q_empty)
  );

  sha_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_word        (q_word),
    .q_pop         (q_pop),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .digest_word   (out_ch.payload.digest_word),
    .word_position (out_ch.payload.word_position),
    .final_word    (out_ch.payload.final_word)
  );
endmodule
`default_nettype wire

// ===== hdl/sha_queue.sv =====
// Small FIFO between input front end and compression back end.
// Depends on sha_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha_queue #(
  parameter int unsigned Depth = sha_pkg::QueueDepth
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire sha_pkg::in_word_t push_word,
  output logic                  full,
  input  wire logic             pop,
  output sha_pkg::in_word_t     pop_word,
  output logic                  empty
);
  import sha_pkg::*;
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  in_word_t         mem [Depth];
  logic [Aw-1:0]    wr_ptr, rd_ptr;
  logic [Aw:0]      count;

  assign full     = (count == (Aw+1)'(Depth));
  assign empty    = (count == '0);
  assign pop_word = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wr_ptr] <= push_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full)
        wr_ptr <= (wr_ptr == Aw'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop && !empty)
        rd_ptr <= (rd_ptr == Aw'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (Aw+1)'(push && !full) - (Aw+1)'(pop && !empty);
    end
  end
endmodule
`default_nettype wire

// ===== hdl/sha_engine.sv =====
// Back end: block packing, padding, 64-round compression, digest output.
// Depends on sha_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha_engine (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  wire sha_pkg::in_word_t q_word,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [31:0]            digest_word,
  output logic [2:0]             word_position,
  output logic                   final_word
);
  import sha_pkg::*;

  localparam logic [2:0] S_FILL  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_COMP  = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]  state;
  word_t       chain [8];
  word_t       v [8];
  word_t       win [16];
  logic [5:0]  fill;
  logic [63:0] length_bits;
  logic [5:0]  round;
  logic        finishing;   // end mark seen: padding phase
  logic        len_block;   // current block carries the length
  logic [2:0]  out_idx;
  logic        lenw_done;   // length words placed in the current block

  word_t w_new, s0w, s1w, wt, t1, t2, S0, S1, ch, maj;
  word_t pad_word;
  logic  [3:0] wi;

  // block bytes live in win[0..15] as big-endian words
  assign wi = fill[5:2];

  always_comb begin
    // win holds w[t..t+15]; w_new is w[t+16]
    s0w = ror(win[1], 7) ^ ror(win[1], 18) ^ (win[1] >> 3);
    s1w = ror(win[14], 17) ^ ror(win[14], 19) ^ (win[14] >> 10);
    w_new = win[0] + s0w + win[9] + s1w;
    // window shifts each round: win[0] is w[t]
    wt  = win[0];
    S1  = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
    ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1  = v[7] + S1 + ch + round_k(round) + wt;
    S0  = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2  = S0 + maj;
  end

  // byte write into the word window
  function automatic word_t put_byte(input word_t w, input logic [1:0] pos,
                                     input logic [7:0] b);
    word_t r;
    r = w;
    unique case (pos)
      2'd0: r[31:24] = b;
      2'd1: r[23:16] = b;
      2'd2: r[15:8]  = b;
      default: r[7:0] = b;
    endcase
    return r;
  endfunction

  always_comb pad_word = put_byte(win[wi], fill[1:0], 8'h00);

  assign q_pop         = (state == S_FILL) && !q_empty;
  assign out_valid     = (state == S_OUT);
  assign digest_word   = chain[out_idx];
  assign word_position = out_idx;
  assign final_word    = (out_idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_FILL;
      fill        <= '0;
      length_bits <= '0;
      round       <= '0;
      finishing   <= 1'b0;
      len_block   <= 1'b0;
      out_idx     <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= init_h(3'(i));
    end else begin
      unique case (state)
        S_FILL: begin
          if (!q_empty) begin
            if (q_word.byte_present) begin
              win[wi] <= put_byte(win[wi], fill[1:0], q_word.data_byte);
              fill        <= fill + 6'd1;
              length_bits <= length_bits + 64'd8;
            end
            if (q_word.byte_present && fill == 6'd63) begin
              for (int i = 0; i < 8; i++) v[i] <= chain[i];
              round     <= '0;
              finishing <= q_word.end_of_message;
              state     <= S_COMP;
            end else if (q_word.end_of_message) begin
              finishing <= 1'b1;
              state     <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // first pad byte is 0x80 when the marker is still due
          if (!len_block) begin
            win[wi] <= put_byte(win[wi], fill[1:0], 8'h80);
            len_block <= 1'b1;
            fill <= fill + 6'd1;
            if (fill == 6'd63) begin
              for (int i = 0; i < 8; i++) v[i] <= chain[i];
              round <= '0;
              state <= S_COMP;
            end
          end else if (fill == 6'd56) begin
            win[14] <= length_bits[63:32];
            win[15] <= length_bits[31:0];
            fill    <= '0;
            for (int i = 0; i < 8; i++) v[i] <= chain[i];
            round   <= '0;
            state   <= S_COMP;
          end else begin
            win[wi] <= pad_word;
            fill    <= fill + 6'd1;
            if (fill == 6'd63) begin
              for (int i = 0; i < 8; i++) v[i] <= chain[i];
              round <= '0;
              state <= S_COMP;
            end
          end
        end
        S_COMP: begin
          for (int i = 0; i < 15; i++) win[i] <= win[i+1];
          win[15] <= w_new;
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0];
          v[0] <= t1 + t2;
          round <= round + 6'd1;
          if (round == 6'(Rounds - 1)) state <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
          if (!finishing) state <= S_FILL;
          else if (len_block && lenw_done) state <= S_OUT;
          else state <= S_PAD;
        end
        S_OUT: begin
          if (out_ready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) chain[i] <= init_h(3'(i));
              fill        <= '0;
              length_bits <= '0;
              finishing   <= 1'b0;
              len_block   <= 1'b0;
              state       <= S_FILL;
            end
          end
        end
        default: state <= S_FILL;
      endcase
    end
  end

  // set once the length words are placed, so the next chaining add is the last
  always_ff @(posedge clk) begin
    if (rst) lenw_done <= 1'b0;
    else if (state == S_PAD && len_block && fill == 6'd56) lenw_done <= 1'b1;
    else if (state == S_OUT) lenw_done <= 1'b0;
  end

endmodule
`default_nettype wire
